// File: sv/conv3x3_edge_clamped_filter_defines.svh
// Assertion macros shared by the checker of the 3x3 convolution filter.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef CONV3X3_EDGE_CLAMPED_FILTER_DEFINES_SVH
`define CONV3X3_EDGE_CLAMPED_FILTER_DEFINES_SVH

// Property checked on every rising edge outside reset
`define CEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included
`define CEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/cef_pkg.sv
// Shared types, constants and register codes of the 3x3 convolution filter.
// No dependencies; used by every module of the block.
package cef_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] REG_KERNEL_MODE   = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [10:0] FRAME_WIDTH_RST   = 11'd640;
  localparam logic [15:0] FRAME_HEIGHT_RST  = 16'd480;
  localparam logic [2:0]  CHANNEL_COUNT_RST = 3'd3;
  localparam logic [1:0]  KERNEL_MODE_RST   = 2'd0;

  // Kernel modes
  localparam logic [1:0] MODE_BOX     = 2'd0;
  localparam logic [1:0] MODE_SHARPEN = 2'd1;
  localparam logic [1:0] MODE_EDGE    = 2'd2;

  // Item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // floor(s/9) == (s * BOX_RECIP) >> BOX_SHIFT for every nine-byte sum
  localparam logic [12:0] BOX_RECIP = 13'd7282;
  localparam int          BOX_SHIFT = 16;

  typedef logic [31:0] word_t;
  typedef word_t [8:0] window_t;

  typedef struct packed {
    logic       op;
    logic [7:0] in_ch0;
    logic [7:0] in_ch1;
    logic [7:0] in_ch2;
    logic [7:0] in_ch3;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [7:0] out_ch3;
    logic       frame_end;
  } result_t;

  // Per-item control decided at accept time
  typedef struct packed {
    logic is_flush;
    logic row0;
    logic load;
    logic emit_mid;
    logic emit_end;
    logic last;
  } item_ctl_t;

endpackage

// File: sv/cef_line_buf.sv
// Two line buffers (rows y-2 and y-1) with registered read data.
// Depends on cef_pkg for the word type.
module cef_line_buf #(
  parameter int MAX_WIDTH = cef_pkg::MAX_WIDTH_DEFAULT,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output cef_pkg::word_t  upper_rd,
  output cef_pkg::word_t  middle_rd,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cef_pkg::word_t  upper_wr,
  input  cef_pkg::word_t  middle_wr
);

  cef_pkg::word_t upper_line  [MAX_WIDTH];
  cef_pkg::word_t middle_line [MAX_WIDTH];

  // Write both rows at one column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_line[wr_addr]  <= upper_wr;
      middle_line[wr_addr] <= middle_wr;
    end
  end

  // Read both rows; hold the data while no new transaction enters
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd  <= upper_line[rd_addr];
      middle_rd <= middle_line[rd_addr];
    end
  end

endmodule

// File: sv/cef_filter.sv
// Kernel arithmetic: box, sharpen or Laplacian per colour byte, clamped to 0..255.
// Depends on cef_pkg for the window and result types and the mode codes.
module cef_filter (
  input  cef_pkg::window_t window,
  input  logic [1:0]       kernel_mode,
  input  logic [2:0]       channel_count,
  input  logic             last,
  output cef_pkg::result_t result
);

  function automatic logic [7:0] kernel_byte(input logic [8:0][7:0] v, input logic [1:0] mode);
    logic [11:0]        sum;
    logic [24:0]        prod;
    logic signed [13:0] c;
    logic signed [13:0] s14;
    logic signed [13:0] r;
    logic [7:0]         y;
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + 12'(v[i]);
    end
    prod = 25'(sum) * 25'(cef_pkg::BOX_RECIP);
    c    = signed'(14'(v[4]));
    s14  = signed'(14'(sum));
    case (mode)
      cef_pkg::MODE_SHARPEN: begin
        r = 14'sd5 * c - signed'(14'(v[1])) - signed'(14'(v[3]))
          - signed'(14'(v[5])) - signed'(14'(v[7]));
      end
      cef_pkg::MODE_EDGE: begin
        r = 14'sd9 * c - s14;
      end
      default: begin
        r = signed'(14'(prod >> cef_pkg::BOX_SHIFT));
      end
    endcase
    if (r < 14'sd0) begin
      y = 8'd0;
    end else if (r > 14'sd255) begin
      y = 8'd255;
    end else begin
      y = r[7:0];
    end
    return y;
  endfunction

  logic [2:0][8:0][7:0] taps;
  logic [2:0][7:0]      filt;
  logic [2:0]           cc;

  // Split the window into per-channel taps
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        taps[ch][i] = window[i][8*ch +: 8];
      end
      filt[ch] = kernel_byte(taps[ch], kernel_mode);
    end
  end

  // Clamp the channel count into 1..4
  always_comb begin
    if (channel_count == 3'd0) begin
      cc = 3'd1;
    end else if (channel_count > 3'd4) begin
      cc = 3'd4;
    end else begin
      cc = channel_count;
    end
  end

  // Route filtered colour bytes and the centre alpha
  always_comb begin
    result.out_ch0   = filt[0];
    result.out_ch1   = 8'd0;
    result.out_ch2   = 8'd0;
    result.out_ch3   = 8'd0;
    result.frame_end = last;
    if (cc == 3'd2) begin
      result.out_ch1 = window[4][15:8];
    end else if (cc >= 3'd3) begin
      result.out_ch1 = filt[1];
      result.out_ch2 = filt[2];
      if (cc == 3'd4) begin
        result.out_ch3 = window[4][31:24];
      end
    end
  end

endmodule

// File: sv/conv3x3_edge_clamped_filter.sv
// Top level of the 3x3 convolution filter with replicated borders.
// Depends on cef_pkg, cef_line_buf and cef_filter.
//
// Takes one pixel transaction per clock, while pixel_stall is low, in raster
// order and returns results one row and one column behind; flush transactions
// then produce the bottom row. Each transaction passes a line-buffer read
// stage, a window stage and the output register, in that order. The last
// column of every row but the first (and of the flush) yields two results,
// which the single output register returns one after the other; the input
// stalls while the second one is pending. The line buffers need no clearing
// after reset.
module conv3x3_edge_clamped_filter #(
  parameter int MAX_WIDTH = cef_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  cef_pkg::pixel_t                  pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output cef_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic [cef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cef_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;

  logic [10:0] frame_width;
  logic [15:0] frame_height;
  logic [2:0]  channel_count;
  logic [1:0]  kernel_mode;

  logic [AW-1:0] column_count;
  logic [15:0]   row_count;
  logic [AW-1:0] flush_count;

  logic [CW-1:0] fw_ext;
  logic [AW-1:0] last_col;
  logic [15:0]   eff_height;

  logic              accept;
  logic              is_flush;
  logic              pix_skip;
  logic              enter;
  logic [AW-1:0]     rd_idx;
  cef_pkg::item_ctl_t ctl_next;

  logic               s1_valid;
  cef_pkg::word_t     s1_pix;
  logic [AW-1:0]      s1_idx;
  cef_pkg::item_ctl_t s1_ctl;
  logic               s1_take;
  logic               s1_go;
  logic               s1_byp;
  cef_pkg::word_t     s1_byp_upper;
  cef_pkg::word_t     s1_byp_middle;

  cef_pkg::word_t upper_rd;
  cef_pkg::word_t middle_rd;
  cef_pkg::word_t upper_cur;
  cef_pkg::word_t middle_cur;
  cef_pkg::word_t upper_wr;
  cef_pkg::word_t top_w;
  cef_pkg::word_t mid_w;
  cef_pkg::word_t bot_w;

  cef_pkg::window_t window_regs;
  cef_pkg::window_t window_next;
  cef_pkg::window_t repl_win;
  cef_pkg::window_t sel_win;

  logic pend_mid;
  logic pend_end;
  logic pend_last;
  logic out_ready;
  logic issue;
  logic s2_take;

  cef_pkg::result_t filt_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= cef_pkg::FRAME_WIDTH_RST;
      frame_height  <= cef_pkg::FRAME_HEIGHT_RST;
      channel_count <= cef_pkg::CHANNEL_COUNT_RST;
      kernel_mode   <= cef_pkg::KERNEL_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cef_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_wdata[10:0];
        cef_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_wdata[15:0];
        cef_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_wdata[2:0];
        cef_pkg::REG_KERNEL_MODE:   kernel_mode   <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Clamp width and height into their working ranges
  always_comb begin
    fw_ext = CW'(frame_width);
    if (fw_ext < CW'(2)) begin
      last_col = AW'(1);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      last_col = AW'(MAX_WIDTH - 1);
    end else begin
      last_col = AW'(fw_ext - CW'(1));
    end
    eff_height = (frame_height < 16'd2) ? 16'd2 : frame_height;
  end

  // Decode the incoming transaction against the frame counters
  always_comb begin
    accept   = pixel_valid && !pixel_stall;
    is_flush = (pixel.op == cef_pkg::OP_FLUSH);
    pix_skip = (flush_count != '0) || (row_count >= eff_height);
    enter    = accept && (is_flush || !pix_skip);
    rd_idx   = is_flush ? flush_count : column_count;
    ctl_next.is_flush = is_flush;
    if (is_flush) begin
      ctl_next.row0     = 1'b0;
      ctl_next.load     = (flush_count == '0);
      ctl_next.emit_mid = (flush_count != '0);
      ctl_next.emit_end = (flush_count >= last_col);
      ctl_next.last     = 1'b1;
    end else begin
      ctl_next.row0     = (row_count == 16'd0);
      ctl_next.load     = (column_count == '0);
      ctl_next.emit_mid = (row_count != 16'd0) && (column_count != '0);
      ctl_next.emit_end = (row_count != 16'd0) && (column_count >= last_col);
      ctl_next.last     = 1'b0;
    end
  end

  // Advance column, row and flush counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      flush_count  <= '0;
    end else if (accept) begin
      if (is_flush) begin
        if (flush_count >= last_col) begin
          column_count <= '0;
          row_count    <= '0;
          flush_count  <= '0;
        end else begin
          flush_count <= flush_count + AW'(1);
        end
      end else if (!pix_skip) begin
        if (column_count >= last_col) begin
          column_count <= '0;
          row_count    <= row_count + 16'd1;
        end else begin
          column_count <= column_count + AW'(1);
        end
      end
    end
  end

  cef_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (enter),
    .rd_addr   (rd_idx),
    .upper_rd  (upper_rd),
    .middle_rd (middle_rd),
    .wr_en     (s1_go && !s1_ctl.is_flush),
    .wr_addr   (s1_idx),
    .upper_wr  (upper_wr),
    .middle_wr (s1_pix)
  );

  // Stage 1: transaction waits for its line-buffer data
  assign s1_take = !s1_valid || s2_take;
  assign s1_go   = s1_valid && s2_take;
  assign pixel_stall = !s1_take;

  // Forward a column written on the same edge that reads it
  assign upper_cur  = s1_byp ? s1_byp_upper : upper_rd;
  assign middle_cur = s1_byp ? s1_byp_middle : middle_rd;
  assign upper_wr   = s1_ctl.row0 ? s1_pix : middle_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= enter;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && enter) begin
      s1_pix        <= {pixel.in_ch3, pixel.in_ch2, pixel.in_ch1, pixel.in_ch0};
      s1_idx        <= rd_idx;
      s1_ctl        <= ctl_next;
      s1_byp        <= s1_go && !s1_ctl.is_flush && (s1_idx == rd_idx);
      s1_byp_upper  <= upper_wr;
      s1_byp_middle <= s1_pix;
    end
  end

  // Form the new window column and load or shift the window
  always_comb begin
    top_w = s1_ctl.row0 ? s1_pix : upper_cur;
    mid_w = s1_ctl.row0 ? s1_pix : middle_cur;
    bot_w = s1_ctl.is_flush ? middle_cur : s1_pix;
    for (int r = 0; r < 3; r++) begin
      if (s1_ctl.load) begin
        window_next[r*3]     = (r == 0) ? top_w : ((r == 1) ? mid_w : bot_w);
        window_next[r*3 + 1] = (r == 0) ? top_w : ((r == 1) ? mid_w : bot_w);
      end else begin
        window_next[r*3]     = window_regs[r*3 + 1];
        window_next[r*3 + 1] = window_regs[r*3 + 2];
      end
      window_next[r*3 + 2] = (r == 0) ? top_w : ((r == 1) ? mid_w : bot_w);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      window_regs <= window_next;
    end
  end

  // Stage 2: up to two results per transaction, one per clock while the output is not stalled
  assign out_ready = !result_valid || !result_stall;
  assign issue     = (pend_mid || pend_end) && out_ready;
  assign s2_take   = !(pend_mid || pend_end) || (out_ready && !(pend_mid && pend_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mid  <= 1'b0;
      pend_end  <= 1'b0;
      pend_last <= 1'b0;
    end else if (s2_take) begin
      pend_mid  <= s1_valid && s1_ctl.emit_mid;
      pend_end  <= s1_valid && s1_ctl.emit_end;
      pend_last <= s1_ctl.last;
    end else if (issue) begin
      pend_mid <= 1'b0;
    end
  end

  // Replicate the right column for the row-end result
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      repl_win[r*3]     = window_regs[r*3 + 1];
      repl_win[r*3 + 1] = window_regs[r*3 + 2];
      repl_win[r*3 + 2] = window_regs[r*3 + 2];
    end
    sel_win = pend_mid ? window_regs : repl_win;
  end

  cef_filter u_filter (
    .window        (sel_win),
    .kernel_mode   (kernel_mode),
    .channel_count (channel_count),
    .last          (!pend_mid && pend_last),
    .result        (filt_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      result <= filt_res;
    end
  end

endmodule

// File: sv/cef_checker.sv
// Port-level checker for the 3x3 convolution filter, bound to the top level.
// Depends on cef_pkg and conv3x3_edge_clamped_filter_defines.svh.
`include "conv3x3_edge_clamped_filter_defines.svh"

module cef_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input cef_pkg::result_t result
);

  // Drop any result at reset
  `CEF_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // Hold a stalled transaction
  `CEF_ASSERT(a_hold_valid, result_valid && result_stall |=> result_valid, "stalled result dropped")
  `CEF_ASSERT(a_hold_data, result_valid && result_stall |=> $stable(result), "stalled result changed")

  // A frame has at least two results, so two frame ends never follow each other
  `CEF_ASSERT(a_frame_end_gap, result_valid && !result_stall && result.frame_end |=> !(result_valid && result.frame_end), "back-to-back frame end")

endmodule

bind conv3x3_edge_clamped_filter cef_checker u_cef_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
